FILE: rtl/lpht_pkg.sv
package lpht_pkg;

   localparam int KEY_W   = 31;
   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 9;
   localparam int CMD_W   = 2;
   localparam int TAG_W   = 2;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
   localparam logic [TAG_W-1:0] TAG_LIVE    = 2'd1;
   localparam logic [TAG_W-1:0] TAG_DELETED = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_READ,
      STATE_CHECK,
      STATE_FINISH
   } state_type;

endpackage

FILE: rtl/lpht_home.sv
module lpht_home #(
   parameter int TABLE_SLOTS = 256,
   parameter int AW          = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [lpht_pkg::KEY_W-1:0] key,
   output logic                     done,
   output logic [AW-1:0]            home
);

   generate
      if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_mask
         logic [AW-1:0] home_ff;

         // power-of-two table: the home slot is the low key bits
         always_ff @(posedge clock) begin
            if (start) begin
               home_ff <= key[AW-1:0];
            end
         end

         assign done = !reset;
         assign home = home_ff;
      end else begin : g_recip
         localparam int          PROD_W = lpht_pkg::KEY_W + 32;
         localparam int          QUOT_W = 32 - AW;
         localparam logic [31:0] RECIP  = 32'(((64'd1 << (lpht_pkg::KEY_W + AW))
                                               + 64'(TABLE_SLOTS) - 64'd1)
                                              / 64'(TABLE_SLOTS));
         localparam logic [31:0] SLOTS  = 32'(TABLE_SLOTS);

         logic [2:0]                 stage_ff;
         logic [lpht_pkg::KEY_W-1:0] key_ff;
         logic [PROD_W-1:0]          prod_ff;
         logic [QUOT_W-1:0]          quot_ff;
         logic [AW-1:0]              rem_ff;
         logic [31:0]                back;
         logic [31:0]                diff;

         // quotient by reciprocal multiply, remainder by multiply back and subtract
         always_comb begin
            back = 32'(quot_ff) * SLOTS;
            diff = {1'b0, key_ff} - back;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
            end else begin
               stage_ff <= {stage_ff[1:0], start};
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff <= key;
            end
            prod_ff <= PROD_W'(key_ff) * PROD_W'(RECIP);
            quot_ff <= prod_ff[PROD_W-1:lpht_pkg::KEY_W+AW];
            rem_ff  <= diff[AW-1:0];
         end

         assign done = (stage_ff == 3'd0) && !start;
         assign home = rem_ff;
      end
   endgenerate

endmodule

FILE: rtl/lpht_store.sv
module lpht_store #(
   parameter int TABLE_SLOTS = 256,
   parameter int AW          = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  lpht_pkg::slot_type       wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output lpht_pkg::slot_type       rd_data
);

   lpht_pkg::slot_type mem [TABLE_SLOTS];
   lpht_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// channel   direction  handshake             payload
// req_      in         req_tvalid/tready     command, key, value
// rsp_      out        rsp_tvalid/tready     found, data, full_res, entry_total
//
// an item probes P slots, P being the slots probed (one read of the slot store each);
// a table size that is not a power of two adds a registered key reduction per item
// after reset a clearing pass writes every slot empty before req_tready
// a stalled response sits in its output register while the next request is taken and probed
module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // command[1:0], key[32:2], value[64:33], zero fill
   input  logic [lpht_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found[0], data[32:1], full_res[33], entry_total[42:34], zero fill
   output logic [lpht_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
   localparam logic [CW-1:0] SLOTS_CW  = CW'(TABLE_SLOTS);

   lpht_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] tgt_idx_ff, tgt_idx_in;
   logic [CW-1:0] probe_ff, probe_in;
   logic [CW-1:0] count_ff, count_in;
   logic          hit_ff, hit_in;
   logic          free_ff, free_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [lpht_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [lpht_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lpht_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [lpht_pkg::VALUE_W-1:0]   hit_value_ff, hit_value_in;
   logic [lpht_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 home_done;
   logic [AW-1:0]        home;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   lpht_pkg::slot_type   wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   lpht_pkg::slot_type   rd_data;
   logic [AW-1:0]        next_idx;
   logic                 slot_hit;
   logic                 slot_free;
   logic                 slot_stop;
   logic                 out_free;
   logic                 found;
   logic                 full_res;
   logic [lpht_pkg::VALUE_W-1:0] data;
   logic [CW-1:0]        count_new;

   assign accept = req_tvalid && req_tready;

   lpht_home #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .AW          (AW)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_tdata[32:2]),
      .done  (home_done),
      .home  (home)
   );

   lpht_store #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::STATE_CLEAR;
         clr_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      tgt_idx_ff   <= tgt_idx_in;
      probe_ff     <= probe_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      hit_value_ff <= hit_value_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // probe step on the slot just read
   always_comb begin
      next_idx  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
      slot_hit  = (rd_data.tag == lpht_pkg::TAG_LIVE) && (rd_data.key == key_ff);
      slot_free = (rd_data.tag != lpht_pkg::TAG_LIVE);
      slot_stop = slot_hit
                  || (slot_free && (rd_data.tag != lpht_pkg::TAG_DELETED))
                  || (probe_ff + 1'b1 == SLOTS_CW);
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      idx_in       = idx_ff;
      tgt_idx_in   = tgt_idx_ff;
      probe_in     = probe_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      hit_value_in = hit_value_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tgt_idx_ff;
      wr_data      = '{tag: lpht_pkg::TAG_LIVE, key: key_ff, value: value_ff};
      rd_en        = 1'b0;
      rd_addr      = home;
      out_free     = !rsp_valid_ff || rsp_tready;
      found        = 1'b0;
      full_res     = 1'b0;
      data         = '0;
      count_new    = count_ff;

      case (state_ff)
         lpht_pkg::STATE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = '{tag: lpht_pkg::TAG_EMPTY, key: '0, value: '0};
            if (clr_idx_ff == LAST_SLOT) begin
               state_in = lpht_pkg::STATE_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         lpht_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = req_tdata[1:0];
               key_in   = req_tdata[32:2];
               value_in = req_tdata[64:33];
               hit_in   = 1'b0;
               free_in  = 1'b0;
               probe_in = '0;
               if (req_tdata[1:0] > lpht_pkg::CMD_REMOVE) begin
                  state_in = lpht_pkg::STATE_FINISH;
               end else begin
                  state_in = lpht_pkg::STATE_READ;
               end
            end
         end

         lpht_pkg::STATE_READ: begin
            if (home_done) begin
               rd_en    = 1'b1;
               rd_addr  = home;
               idx_in   = home;
               state_in = lpht_pkg::STATE_CHECK;
            end
         end

         lpht_pkg::STATE_CHECK: begin
            if (slot_hit) begin
               hit_in       = 1'b1;
               hit_value_in = rd_data.value;
               tgt_idx_in   = idx_ff;
            end else if (slot_free && !free_ff) begin
               free_in    = 1'b1;
               tgt_idx_in = idx_ff;
            end
            if (slot_stop) begin
               state_in = lpht_pkg::STATE_FINISH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = next_idx;
               idx_in   = next_idx;
               probe_in = probe_ff + 1'b1;
            end
         end

         lpht_pkg::STATE_FINISH: begin
            found = hit_ff;
            case (cmd_ff)
               lpht_pkg::CMD_PUT: begin
                  if (hit_ff) begin
                     wr_en = 1'b1;
                  end else if (free_ff) begin
                     wr_en     = 1'b1;
                     count_new = count_ff + 1'b1;
                  end else begin
                     full_res = 1'b1;
                  end
               end
               lpht_pkg::CMD_GET: begin
                  if (hit_ff) begin
                     data = hit_value_ff;
                  end
               end
               lpht_pkg::CMD_REMOVE: begin
                  if (hit_ff) begin
                     data      = hit_value_ff;
                     wr_en     = 1'b1;
                     wr_data   = '{tag: lpht_pkg::TAG_DELETED, key: key_ff,
                                   value: hit_value_ff};
                     count_new = count_ff - 1'b1;
                  end
               end
               default: begin
                  found = 1'b0;
               end
            endcase
            if (out_free) begin
               count_in     = count_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, lpht_pkg::TOTAL_W'(count_new), full_res, data, found};
               state_in     = lpht_pkg::STATE_IDLE;
            end else begin
               wr_en = 1'b0;
            end
         end

         default: begin
            state_in = lpht_pkg::STATE_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/sv/tb_linear_probe_hash_table.sv
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;

   localparam int SLOTS       = 256;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 800000;
   localparam logic [lpht_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [lpht_pkg::KEY_W-1:0] KEY_MAX    = '1;

   typedef struct packed {
      logic [lpht_pkg::TOTAL_W-1:0] entry_total;
      logic                         full_res;
      logic [lpht_pkg::VALUE_W-1:0] data;
      logic                         found;
   } reply_type;

   class table_mirror;
      logic [lpht_pkg::TAG_W-1:0]   slot_tag [SLOTS];
      logic [lpht_pkg::KEY_W-1:0]   slot_key [SLOTS];
      logic [lpht_pkg::VALUE_W-1:0] slot_value [SLOTS];
      int live;
      int peak;
      int errors;
      int puts, gets, removes, unused, hits, refused;
      reply_type pending_replies[$];

      function new();
         foreach (slot_tag[i]) slot_tag[i] = lpht_pkg::TAG_EMPTY;
         live = 0;
         peak = 0;
         errors = 0;
         puts = 0;
         gets = 0;
         removes = 0;
         unused = 0;
         hits = 0;
         refused = 0;
      endfunction

      // walk from the home slot; stop on empty, on the key, or after a full circle
      function void probe(input logic [lpht_pkg::KEY_W-1:0] k, output int hit,
                          output int vacancy);
         int idx;
         idx = k % SLOTS;
         hit = -1;
         vacancy = -1;
         for (int n = 0; n < SLOTS; n++) begin
            if (slot_tag[idx] == lpht_pkg::TAG_LIVE) begin
               if (slot_key[idx] == k) begin
                  hit = idx;
                  return;
               end
            end else begin
               if (vacancy < 0) vacancy = idx;
               if (slot_tag[idx] != lpht_pkg::TAG_DELETED) return;
            end
            idx = (idx + 1) % SLOTS;
         end
      endfunction

      function bit holds(input logic [lpht_pkg::KEY_W-1:0] k);
         int hit, vacancy;
         probe(k, hit, vacancy);
         return hit >= 0;
      endfunction

      function void apply_request(input logic [lpht_pkg::CMD_W-1:0] cmd,
                                  input logic [lpht_pkg::KEY_W-1:0] key,
                                  input logic [lpht_pkg::VALUE_W-1:0] value);
         reply_type r;
         int hit, vacancy;
         r = '0;
         if (cmd == CMD_UNUSED) begin
            unused++;
         end else begin
            probe(key, hit, vacancy);
            r.found = hit >= 0;
            if (hit >= 0) hits++;
            case (cmd)
               lpht_pkg::CMD_PUT: begin
                  puts++;
                  if (hit >= 0) begin
                     slot_value[hit] = value;
                  end else if (vacancy >= 0) begin
                     slot_tag[vacancy] = lpht_pkg::TAG_LIVE;
                     slot_key[vacancy] = key;
                     slot_value[vacancy] = value;
                     live++;
                  end else begin
                     r.full_res = 1'b1;
                     refused++;
                  end
               end
               lpht_pkg::CMD_GET: begin
                  gets++;
                  if (hit >= 0) r.data = slot_value[hit];
               end
               default: begin
                  removes++;
                  if (hit >= 0) begin
                     r.data = slot_value[hit];
                     slot_tag[hit] = lpht_pkg::TAG_DELETED;
                     if (live > 0) live--;
                  end
               end
            endcase
         end
         if (live > peak) peak = live;
         r.entry_total = lpht_pkg::TOTAL_W'(live);
         pending_replies.push_back(r);
      endfunction

      function void check_response(input logic [lpht_pkg::RSP_TDATA_W-1:0] word);
         reply_type got, want;
         got = word[$bits(reply_type)-1:0];
         if (pending_replies.size() == 0) begin
            $error("response with nothing outstanding: %h", word);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            errors++;
         end
         if (got.data !== want.data) begin
            $error("data: expected %h, got %h", want.data, got.data);
            errors++;
         end
         if (got.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
            errors++;
         end
         if (got.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [lpht_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [lpht_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   table_mirror mirror = new();
   logic [lpht_pkg::KEY_W-1:0] used_keys[$];
   int  gap_pct = 25;
   bit  long_hold_due = 1'b0;
   longint cycle_count = 0;

   linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_linear_probe_hash_table: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata);
   end

   // response side: random stalls, one long hold-off on request
   initial begin : receiver
      int stretch;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            stretch = LONG_HOLD;
         end else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            rsp_tready <= 1'b0;
            stretch = $urandom_range(1, 17);
         end else begin
            rsp_tready <= 1'b1;
            stretch = 1;
         end
         repeat (stretch) @(negedge clock);
      end
   end

   task automatic send_request(input logic [lpht_pkg::CMD_W-1:0] cmd,
                               input logic [lpht_pkg::KEY_W-1:0] key,
                               input logic [lpht_pkg::VALUE_W-1:0] value);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(lpht_pkg::REQ_TDATA_W - lpht_pkg::CMD_W - lpht_pkg::KEY_W
                       - lpht_pkg::VALUE_W){1'b0}}, value, key, cmd};
      if (cmd == lpht_pkg::CMD_PUT) used_keys.push_back(key);
      do @(posedge clock); while (!req_tready);
      mirror.apply_request(cmd, key, value);
      @(negedge clock);
   endtask

   function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && used_keys.size() != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      // clustered around the end of the table so chains wrap
      if (r < 70)
         return {(lpht_pkg::KEY_W - 8)'($urandom), 8'($urandom_range(240, 271))};
      return lpht_pkg::KEY_W'($urandom);
   endfunction

   function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key();
      logic [lpht_pkg::KEY_W-1:0] k;
      do k = lpht_pkg::KEY_W'($urandom); while (mirror.holds(k));
      return k;
   endfunction

   task automatic random_request(input int put_pct);
      int r;
      logic [lpht_pkg::CMD_W-1:0] cmd;
      r = $urandom_range(0, 99);
      if (r < put_pct) cmd = lpht_pkg::CMD_PUT;
      else if (r < put_pct + (96 - put_pct) / 2) cmd = lpht_pkg::CMD_GET;
      else if (r < 96) cmd = lpht_pkg::CMD_REMOVE;
      else cmd = CMD_UNUSED;
      send_request(cmd, pick_key(), $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners on a fresh table
      send_request(lpht_pkg::CMD_GET, '0, '0);
      send_request(lpht_pkg::CMD_REMOVE, 31'd5, '0);
      send_request(CMD_UNUSED, KEY_MAX, '1);
      send_request(lpht_pkg::CMD_PUT, '0, '0);
      send_request(lpht_pkg::CMD_PUT, KEY_MAX, '1);
      send_request(lpht_pkg::CMD_PUT, 31'd255, 32'h1234_5678);
      send_request(lpht_pkg::CMD_GET, 31'd255, '0);
      send_request(lpht_pkg::CMD_GET, KEY_MAX, '0);
      send_request(lpht_pkg::CMD_PUT, '0, 32'hA5A5_A5A5);
      send_request(lpht_pkg::CMD_GET, '0, '0);
      send_request(lpht_pkg::CMD_PUT, 31'd5, 32'h0000_0001);
      send_request(lpht_pkg::CMD_PUT, 31'd261, 32'h0000_0002);
      send_request(lpht_pkg::CMD_PUT, 31'd517, 32'h0000_0003);
      send_request(lpht_pkg::CMD_REMOVE, 31'd261, '0);
      send_request(lpht_pkg::CMD_GET, 31'd517, '0);
      send_request(lpht_pkg::CMD_GET, 31'd261, '0);
      send_request(lpht_pkg::CMD_REMOVE, 31'd261, '0);
      send_request(lpht_pkg::CMD_PUT, 31'd773, 32'h8000_0000);
      send_request(lpht_pkg::CMD_PUT, 31'd517, 32'hFFFF_0000);
      send_request(lpht_pkg::CMD_REMOVE, 31'd5, '0);
      send_request(lpht_pkg::CMD_REMOVE, 31'd5, '0);
      send_request(CMD_UNUSED, 31'd773, 32'h5555_5555);
      send_request(lpht_pkg::CMD_GET, 31'd773, '0);
      send_request(lpht_pkg::CMD_PUT, 31'h2AAA_AAAA, 32'h5555_5555);
      send_request(lpht_pkg::CMD_PUT, 31'h5555_5555, 32'hAAAA_AAAA);

      // back-pressure: sender keeps offering while the response side holds off
      gap_pct = 0;
      long_hold_due = 1'b1;
      repeat (70) random_request(50);
      gap_pct = 15;
      repeat (70) random_request(50);

      // fill to capacity, then work the full table
      gap_pct = 8;
      while (mirror.live < SLOTS) send_request(lpht_pkg::CMD_PUT, fresh_key(), $urandom);
      repeat (6) send_request(lpht_pkg::CMD_PUT, fresh_key(), $urandom);
      repeat (4) send_request(lpht_pkg::CMD_GET, fresh_key(), '0);
      repeat (4) send_request(lpht_pkg::CMD_PUT,
                              used_keys[$urandom_range(0, used_keys.size() - 1)], $urandom);
      repeat (4) send_request(lpht_pkg::CMD_GET,
                              used_keys[$urandom_range(0, used_keys.size() - 1)], '0);
      send_request(CMD_UNUSED, fresh_key(), $urandom);
      repeat (40) random_request(20);

      // closing stretch with no idling on either side
      gap_pct = 0;
      repeat (40) random_request(40);
      req_tvalid <= 1'b0;

      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("exercised %0d puts, %0d gets, %0d removes, %0d unrecognised commands, %0d hits",
               mirror.puts, mirror.gets, mirror.removes, mirror.unused, mirror.hits);
      $display("table peaked at %0d entries, %0d puts refused as full, %0d mismatches",
               mirror.peak, mirror.refused, mirror.errors);
      if (mirror.errors == 0) begin
         $display("tb_linear_probe_hash_table: PASS");
      end else begin
         $display("tb_linear_probe_hash_table: FAIL");
      end
      $finish;
   end

endmodule

FILE: linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_home.sv
rtl/lpht_store.sv
rtl/linear_probe_hash_table.sv
tb/sv/tb_linear_probe_hash_table.sv
